// ===== rtl/assert_macros.svh =====
// assertion macros shared by the engine's modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define ASSERT_SAME(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== rtl/msne_pkg.sv =====
// types, codes and constants of the native mode engine
`timescale 1ns / 1ps

package msne_pkg;

   // defaults and fixed limits
   localparam int ENCODER_COUNT_DEFAULT = 16;
   localparam logic [7:0] MAX_DISPLAY_TYPE = 8'd4;

   // item kinds
   localparam logic [2:0] KIND_SYSEX  = 3'd0;
   localparam logic [2:0] KIND_MIDI   = 3'd1;
   localparam logic [2:0] KIND_TOGGLE = 3'd2;
   localparam logic [2:0] KIND_TURN   = 3'd3;
   localparam logic [2:0] KIND_ENC_SW = 3'd4;
   localparam logic [2:0] KIND_SIDE_SW = 3'd5;
   localparam logic [2:0] KIND_QUERY  = 3'd6;

   // result kinds
   localparam logic [1:0] RESULT_NONE    = 2'd0;
   localparam logic [1:0] RESULT_CC      = 2'd1;
   localparam logic [1:0] RESULT_REFRESH = 2'd2;
   localparam logic [1:0] RESULT_DISPLAY = 2'd3;

   // outgoing cc channels
   localparam logic [1:0] CC_CH_POSITION = 2'd0;
   localparam logic [1:0] CC_CH_ENC_SW   = 2'd1;
   localparam logic [1:0] CC_CH_SIDE_SW  = 2'd2;

   // sysex commands and record selectors
   localparam logic [7:0] SYSEX_CMD_MODE    = 8'd0;
   localparam logic [7:0] SYSEX_CMD_RECORDS = 8'd1;
   localparam logic [7:0] SYSEX_SEL_IND     = 8'd0;
   localparam logic [7:0] SYSEX_SEL_COLOUR  = 8'd1;

   // sysex parse phases
   typedef enum logic [3:0] {
      PH_CMD       = 4'd0,
      PH_MODE_VAL  = 4'd1,
      PH_MODE_HAVE = 4'd2,
      PH_SKIP      = 4'd3,
      PH_SEL       = 4'd4,
      PH_IND0      = 4'd5,
      PH_IND1      = 4'd6,
      PH_IND2      = 4'd7,
      PH_IND3      = 4'd8,
      PH_SW0       = 4'd9,
      PH_SW1       = 4'd10,
      PH_SW2       = 4'd11,
      PH_SW3       = 4'd12
   } phase_type;

   // controller states
   typedef enum logic {
      CTRL_IDLE = 1'b0,
      CTRL_EXEC = 1'b1
   } ctrl_state_type;

   // input item
   typedef struct packed {
      logic [2:0]        kind;
      logic [7:0]        data_byte;
      logic              data_last;
      logic              is_control_change;
      logic [3:0]        midi_channel;
      logic [6:0]        midi_number;
      logic [6:0]        midi_value;
      logic [5:0]        encoder_index;
      logic signed [7:0] delta;
      logic              pressed;
   } msne_req_type;

   // result item
   typedef struct packed {
      logic [1:0]  result_kind;
      logic        accepted;
      logic [1:0]  cc_channel;
      logic [5:0]  cc_number;
      logic [6:0]  cc_value;
      logic [6:0]  level;
      logic        detent_on;
      logic [6:0]  display_style;
      logic [6:0]  detent_colour;
      logic [23:0] rgb_colour;
   } msne_rsp_type;

   // controller to datapath commands
   typedef struct packed {
      logic capture;
      logic execute;
   } msne_cmd_type;

endpackage

// ===== rtl/msne_ctrl.sv =====
// controller: sequences capture and execution of one item
`timescale 1ns / 1ps
`include "assert_macros.svh"

module msne_ctrl
   import msne_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   output msne_cmd_type cmd
);

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CTRL_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         CTRL_IDLE: begin
            if (start) state_in = CTRL_EXEC;
         end
         CTRL_EXEC: begin
            state_in = CTRL_IDLE;
         end
         default: begin
            state_in = CTRL_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      busy        = 1'b0;
      cmd.capture = 1'b0;
      cmd.execute = 1'b0;
      case (state_ff)
         CTRL_IDLE: begin
            cmd.capture = start;
         end
         CTRL_EXEC: begin
            busy        = 1'b1;
            cmd.execute = 1'b1;
         end
         default: begin
            busy = 1'b0;
         end
      endcase
   end

   `ASSERT_NEXT(a_accept_then_busy, clock, reset, start && !busy, busy)
   `ASSERT_NEXT(a_busy_one_cycle, clock, reset, busy, !busy)
   `ASSERT_SAME(a_capture_on_accept, clock, reset, cmd.capture, start && !busy)

endmodule

// ===== rtl/msne_datapath.sv =====
// datapath: sysex parser, per-encoder stores and result formation
`timescale 1ns / 1ps
`include "assert_macros.svh"

module msne_datapath
   import msne_pkg::*;
#(
   parameter int ENCODER_COUNT = ENCODER_COUNT_DEFAULT
)
(
   input  logic         clock,
   input  logic         reset,
   input  msne_cmd_type cmd,
   input  msne_req_type req_item,
   output logic         rsp_strobe,
   output msne_rsp_type rsp_item
);

   localparam int AW = (ENCODER_COUNT > 1) ? $clog2(ENCODER_COUNT) : 1;
   localparam logic [7:0] ENC_BYTE  = 8'(ENCODER_COUNT);
   localparam logic [6:0] ENC_LIMIT = 7'(ENCODER_COUNT);

   // captured item and results
   msne_req_type req_ff;
   msne_rsp_type rsp_item_ff;
   msne_rsp_type rsp_item_in;
   logic         rsp_strobe_ff;

   // control state
   logic               mode_active_ff;
   logic               mode_active_in;
   phase_type          phase_ff;
   phase_type          phase_in;
   logic [27:0]        record_ff;
   logic [27:0]        record_in;
   logic [ENCODER_COUNT-1:0] ind_valid_ff;
   logic [ENCODER_COUNT-1:0] ind_valid_in;
   logic [ENCODER_COUNT-1:0] col_valid_ff;
   logic [ENCODER_COUNT-1:0] col_valid_in;
   logic [ENCODER_COUNT-1:0] lvl_valid_ff;
   logic [ENCODER_COUNT-1:0] lvl_valid_in;

   // per-encoder memories and their read registers
   logic [14:0] ind_mem_ff [ENCODER_COUNT];
   logic [20:0] col_mem_ff [ENCODER_COUNT];
   logic [6:0]  lvl_mem_ff [ENCODER_COUNT];
   logic [14:0] ind_rd_ff;
   logic [20:0] col_rd_ff;
   logic [6:0]  lvl_rd_ff;

   // write ports
   logic          ind_wr_en;
   logic          col_wr_en;
   logic          lvl_wr_en;
   logic [AW-1:0] rec_wr_addr;
   logic [AW-1:0] lvl_wr_addr;
   logic [14:0]   ind_wr_data;
   logic [20:0]   col_wr_data;
   logic [6:0]    lvl_wr_data;

   // parser helpers
   logic        is_ind;
   logic [1:0]  rec_pos;
   logic        byte_ok;
   logic        clear_settings;
   logic        refresh;
   logic [AW-1:0] q_addr;
   logic        q_in_range;
   logic signed [8:0] turn_sum;
   logic [6:0]  turn_value;

   // item capture and memory reads
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff    <= req_item;
         ind_rd_ff <= ind_mem_ff[req_item.encoder_index[AW-1:0]];
         col_rd_ff <= col_mem_ff[req_item.encoder_index[AW-1:0]];
         lvl_rd_ff <= lvl_mem_ff[req_item.encoder_index[AW-1:0]];
      end
      if (ind_wr_en) ind_mem_ff[rec_wr_addr] <= ind_wr_data;
      if (col_wr_en) col_mem_ff[rec_wr_addr] <= col_wr_data;
      if (lvl_wr_en) lvl_mem_ff[lvl_wr_addr] <= lvl_wr_data;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_active_ff <= 1'b0;
         phase_ff       <= PH_CMD;
         record_ff      <= '0;
         ind_valid_ff   <= '0;
         col_valid_ff   <= '0;
         lvl_valid_ff   <= '0;
         rsp_strobe_ff  <= 1'b0;
      end else begin
         mode_active_ff <= mode_active_in;
         phase_ff       <= phase_in;
         record_ff      <= record_in;
         ind_valid_ff   <= ind_valid_in;
         col_valid_ff   <= col_valid_in;
         lvl_valid_ff   <= lvl_valid_in;
         rsp_strobe_ff  <= cmd.execute;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.execute) rsp_item_ff <= rsp_item_in;
   end

   // record position and byte check
   always_comb begin
      is_ind  = (phase_ff inside {[PH_IND0:PH_IND3]});
      rec_pos = is_ind ? 2'(phase_ff - PH_IND0) : 2'(phase_ff - PH_SW0);
      if (rec_pos == 2'd0) begin
         byte_ok = req_ff.data_byte < ENC_BYTE;
      end else if (is_ind && rec_pos == 2'd1) begin
         byte_ok = req_ff.data_byte <= MAX_DISPLAY_TYPE;
      end else if (is_ind && rec_pos == 2'd2) begin
         byte_ok = req_ff.data_byte <= 8'd1;
      end else begin
         byte_ok = req_ff.data_byte <= 8'h7F;
      end
   end

   // turn value, 64 + delta clamped to 0..127
   always_comb begin
      turn_sum = 9'(req_ff.delta) + 9'sd64;
      if (turn_sum < 9'sd0) begin
         turn_value = 7'd0;
      end else if (turn_sum > 9'sd127) begin
         turn_value = 7'h7F;
      end else begin
         turn_value = turn_sum[6:0];
      end
   end

   assign q_addr     = req_ff.encoder_index[AW-1:0];
   assign q_in_range = {1'b0, req_ff.encoder_index} < ENC_LIMIT;

   // item execution
   always_comb begin
      mode_active_in = mode_active_ff;
      phase_in       = phase_ff;
      record_in      = record_ff;
      ind_valid_in   = ind_valid_ff;
      col_valid_in   = col_valid_ff;
      lvl_valid_in   = lvl_valid_ff;
      rsp_item_in    = '0;
      ind_wr_en      = 1'b0;
      col_wr_en      = 1'b0;
      lvl_wr_en      = 1'b0;
      rec_wr_addr    = '0;
      lvl_wr_addr    = req_ff.midi_number[AW-1:0];
      ind_wr_data    = '0;
      col_wr_data    = '0;
      lvl_wr_data    = req_ff.midi_value;
      clear_settings = 1'b0;
      refresh        = 1'b0;

      if (cmd.execute) begin
         case (req_ff.kind)
            KIND_SYSEX: begin
               // one parser step
               case (phase_ff)
                  PH_CMD: begin
                     if (req_ff.data_byte == SYSEX_CMD_MODE) begin
                        phase_in = PH_MODE_VAL;
                     end else if (req_ff.data_byte == SYSEX_CMD_RECORDS) begin
                        phase_in = mode_active_ff ? PH_SEL : PH_SKIP;
                     end else begin
                        phase_in = PH_SKIP;
                     end
                  end
                  PH_MODE_VAL: begin
                     record_in = {20'd0, req_ff.data_byte};
                     phase_in  = PH_MODE_HAVE;
                  end
                  PH_SEL: begin
                     if (req_ff.data_byte == SYSEX_SEL_IND) begin
                        phase_in = PH_IND0;
                     end else if (req_ff.data_byte == SYSEX_SEL_COLOUR) begin
                        phase_in = PH_SW0;
                     end else begin
                        phase_in = PH_SKIP;
                     end
                  end
                  PH_IND0, PH_IND1, PH_IND2, PH_IND3,
                  PH_SW0, PH_SW1, PH_SW2, PH_SW3: begin
                     if (!byte_ok) begin
                        phase_in = PH_SKIP;
                     end else begin
                        case (rec_pos)
                           2'd0:    record_in[6:0]   = req_ff.data_byte[6:0];
                           2'd1:    record_in[13:7]  = req_ff.data_byte[6:0];
                           2'd2:    record_in[20:14] = req_ff.data_byte[6:0];
                           default: record_in[27:21] = req_ff.data_byte[6:0];
                        endcase
                        if (rec_pos != 2'd3) begin
                           phase_in = phase_type'(phase_ff + 4'd1);
                        end else begin
                           // record complete: write it
                           rec_wr_addr = record_in[AW-1:0];
                           ind_wr_data = {record_in[27:21], record_in[14], record_in[13:7]};
                           col_wr_data = {record_in[13:7], record_in[20:14], record_in[27:21]};
                           ind_wr_en   = is_ind;
                           col_wr_en   = !is_ind;
                           if (is_ind) begin
                              ind_valid_in[rec_wr_addr] = 1'b1;
                           end else begin
                              col_valid_in[rec_wr_addr] = 1'b1;
                           end
                           phase_in = PH_SEL;
                        end
                     end
                  end
                  default: begin
                     phase_in = PH_SKIP;
                  end
               endcase

               // end of message
               if (req_ff.data_last) begin
                  if (phase_in == PH_MODE_HAVE && record_in <= 28'd1) begin
                     if (record_in[0] != mode_active_ff) begin
                        mode_active_in = record_in[0];
                        clear_settings = record_in[0];
                        refresh        = 1'b1;
                     end
                  end else if (phase_in == PH_SEL) begin
                     refresh = 1'b1;
                  end
                  phase_in  = PH_CMD;
                  record_in = '0;
               end
               if (refresh) begin
                  rsp_item_in.result_kind = RESULT_REFRESH;
                  rsp_item_in.accepted    = 1'b1;
               end
            end
            KIND_MIDI: begin
               if (mode_active_ff && req_ff.is_control_change &&
                   req_ff.midi_channel == 4'd0 && req_ff.midi_number < ENC_LIMIT) begin
                  lvl_wr_en                 = 1'b1;
                  lvl_valid_in[lvl_wr_addr] = 1'b1;
                  rsp_item_in.accepted      = 1'b1;
               end
            end
            KIND_TOGGLE: begin
               mode_active_in          = !mode_active_ff;
               clear_settings          = !mode_active_ff;
               rsp_item_in.result_kind = RESULT_REFRESH;
               rsp_item_in.accepted    = 1'b1;
            end
            KIND_TURN: begin
               if (mode_active_ff) begin
                  rsp_item_in.result_kind = RESULT_CC;
                  rsp_item_in.accepted    = 1'b1;
                  rsp_item_in.cc_channel  = CC_CH_POSITION;
                  rsp_item_in.cc_number   = req_ff.encoder_index;
                  rsp_item_in.cc_value    = turn_value;
               end
            end
            KIND_ENC_SW, KIND_SIDE_SW: begin
               if (mode_active_ff) begin
                  rsp_item_in.result_kind = RESULT_CC;
                  rsp_item_in.accepted    = 1'b1;
                  rsp_item_in.cc_channel  = (req_ff.kind == KIND_ENC_SW) ?
                                            CC_CH_ENC_SW : CC_CH_SIDE_SW;
                  rsp_item_in.cc_number   = req_ff.encoder_index;
                  rsp_item_in.cc_value    = req_ff.pressed ? 7'h7F : 7'd0;
               end
            end
            KIND_QUERY: begin
               if (mode_active_ff && q_in_range) begin
                  rsp_item_in.result_kind = RESULT_DISPLAY;
                  rsp_item_in.accepted    = 1'b1;
                  if (lvl_valid_ff[q_addr]) begin
                     rsp_item_in.level = lvl_rd_ff;
                  end
                  if (ind_valid_ff[q_addr]) begin
                     rsp_item_in.display_style = ind_rd_ff[6:0];
                     rsp_item_in.detent_on     = ind_rd_ff[7];
                     rsp_item_in.detent_colour = ind_rd_ff[14:8];
                  end
                  if (col_valid_ff[q_addr]) begin
                     rsp_item_in.rgb_colour = {col_rd_ff[20:14], 1'b0,
                                               col_rd_ff[13:7], 1'b0,
                                               col_rd_ff[6:0], 1'b0};
                  end
               end
            end
            default: begin
               rsp_item_in = '0;
            end
         endcase

         // entering the mode wipes indicator settings and colours
         if (clear_settings) begin
            ind_valid_in = '0;
            col_valid_in = '0;
         end
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_item_ff;

   `ASSERT_NEXT(a_exec_gives_result, clock, reset, cmd.execute, rsp_strobe_ff)
   `ASSERT_NEXT(a_no_spurious_result, clock, reset, !cmd.execute, !rsp_strobe_ff)
   `ASSERT_NEXT(a_last_byte_rearms, clock, reset,
      cmd.execute && req_ff.kind == KIND_SYSEX && req_ff.data_last,
      phase_ff == PH_CMD && record_ff == 28'd0)

endmodule

// ===== rtl/midi_surface_native_mode_engine.sv =====
// top level of the control surface native mode engine
`timescale 1ns / 1ps

// An item is taken at a clock edge where start is high and busy is low; busy
// then stays high for exactly one cycle while the item executes, so no new item
// is taken while one executes. The encoder stores are read at the accept
// edge and the execution state does the parse step, the store writes
// and the result; the result appears on rsp_item with rsp_strobe high for
// exactly one cycle, the cycle after execution, and must be taken then since
// the receiver cannot stall. Every item gives exactly one result. A new item
// may be taken in the same cycle that the previous result is shown. No
// clearing pass is needed after reset: the block is ready at once.
module midi_surface_native_mode_engine
   import msne_pkg::*;
#(
   parameter int ENCODER_COUNT = ENCODER_COUNT_DEFAULT
)
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  msne_req_type req_item,
   output logic         rsp_strobe,
   output msne_rsp_type rsp_item
);

   msne_cmd_type cmd;

   // sequencing
   msne_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd)
   );

   // parser, stores and results
   msne_datapath #(
      .ENCODER_COUNT (ENCODER_COUNT)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

endmodule
